@@ rtl/core/three_channel_normalize_ema_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the three-channel normalize and average unit
// Concurrent property wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_NORMALIZE_EMA_UNIT_ASSERT_SVH
`define THREE_CHANNEL_NORMALIZE_EMA_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define TCNE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TCNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCNE_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TCNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/tcne_pkg.sv @@
// ----------------------------------------------------------------------------
// tcne_pkg
// Shared widths, register map, reset values and control types.
// ----------------------------------------------------------------------------
package tcne_pkg;

  localparam int DATA_W             = 32;
  localparam int WEIGHT_W           = 16;
  localparam int OUT_W              = 15;
  localparam int PADDR_W            = 4;
  localparam int LEVEL_FRAC_DEFAULT = 8;
  localparam int LEVEL_SCALE        = 100;

  // Register indexes (byte address bits 3:2).
  localparam logic [1:0] REG_CPU_SCALE = 2'd0;
  localparam logic [1:0] REG_MEM_SCALE = 2'd1;
  localparam logic [1:0] REG_IO_SCALE  = 2'd2;
  localparam logic [1:0] REG_WEIGHT    = 2'd3;

  localparam logic [DATA_W-1:0]   CPU_SCALE_RESET = 32'd100;
  localparam logic [DATA_W-1:0]   MEM_SCALE_RESET = 32'd8192;
  localparam logic [DATA_W-1:0]   IO_SCALE_RESET  = 32'd1000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 16'd45875;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } tcne_ctrl_t;

endpackage

@@ rtl/core/tcne_div.sv @@
// ----------------------------------------------------------------------------
// tcne_div
// Bit-serial restoring divider that turns a raw sample into a fixed point
// level, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcne_div #(
  parameter int FRAC_BITS = tcne_pkg::LEVEL_FRAC_DEFAULT
) (
  input  logic                                                   clk,
  input  tcne_pkg::tcne_ctrl_t                                   ctrl,
  input  logic [tcne_pkg::DATA_W-1:0]                            sample,
  input  logic [tcne_pkg::DATA_W-1:0]                            scale,
  output logic [$clog2((tcne_pkg::LEVEL_SCALE << FRAC_BITS) + 1)-1:0] level
);
  import tcne_pkg::*;

  localparam int LW = $clog2((LEVEL_SCALE << FRAC_BITS) + 1);
  localparam int PW = DATA_W + LW;
  localparam logic [LW-1:0] FULL_LEVEL = LW'(LEVEL_SCALE << FRAC_BITS);

  logic [PW-1:0]     dividend;
  logic [DATA_W-1:0] rem;
  logic [LW-1:0]     low_bits;
  logic [LW-1:0]     quo;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;
  logic              sat;
  logic              zero_scale;

  // sample * 100 by shifts and adds, then the fraction bits below it.
  // The product is below 2^(32+7), and 100 * 2^F lies in [2^(F+6), 2^(F+7)),
  // so the part above the quotient bits is exactly one data word.
  assign dividend = (PW'(sample) << (6 + FRAC_BITS)) + (PW'(sample) << (5 + FRAC_BITS))
                  + (PW'(sample) << (2 + FRAC_BITS));

  assign trial = {rem, low_bits[LW-1]};
  assign diff  = trial - {1'b0, scale};
  assign fits  = (trial >= {1'b0, scale});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem        <= dividend[PW-1:LW];
      low_bits   <= dividend[LW-1:0];
      quo        <= '0;
      sat        <= (sample >= scale);
      zero_scale <= (scale == '0);
    end else if (ctrl.step) begin
      rem      <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      low_bits <= {low_bits[LW-2:0], 1'b0};
      quo      <= {quo[LW-2:0], fits};
    end
  end

  // A sample at or above full scale never reaches the divider result.
  always_comb begin
    priority if (zero_scale) begin
      level = '0;
    end else if (sat) begin
      level = FULL_LEVEL;
    end else begin
      level = quo;
    end
  end

endmodule

@@ rtl/core/tcne_blend.sv @@
// ----------------------------------------------------------------------------
// tcne_blend
// Holds one channel average and blends a new level into it with a
// bit-serial multiply by the smoothing weight.
// ----------------------------------------------------------------------------
module tcne_blend #(
  parameter int FRAC_BITS = tcne_pkg::LEVEL_FRAC_DEFAULT
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  tcne_pkg::tcne_ctrl_t                                   ctrl,
  input  logic                                                   primed,
  input  logic [tcne_pkg::WEIGHT_W-1:0]                          weight,
  input  logic [$clog2((tcne_pkg::LEVEL_SCALE << FRAC_BITS) + 1)-1:0] level,
  output logic [$clog2((tcne_pkg::LEVEL_SCALE << FRAC_BITS) + 1)-1:0] avg_next
);
  import tcne_pkg::*;

  localparam int LW = $clog2((LEVEL_SCALE << FRAC_BITS) + 1);
  localparam int AW = LW + WEIGHT_W + 1;

  logic [LW-1:0]           avg;
  logic [LW-1:0]           lev;
  logic signed [LW:0]      delta;
  logic signed [AW-1:0]    delta_ext;
  logic signed [AW-1:0]    acc;
  logic signed [AW-1:0]    acc_sh;
  logic [WEIGHT_W-1:0]     wsr;
  logic signed [LW+1:0]    sum;

  // w*old + (1-w)*new = new + w*(old - new); the product is built MSB first.
  assign delta_ext = AW'(delta);
  assign acc_sh    = acc >>> WEIGHT_W;
  assign sum       = $signed({2'b00, lev}) + $signed(acc_sh[LW+1:0]);
  assign avg_next  = primed ? sum[LW-1:0] : lev;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      delta <= $signed({1'b0, avg}) - $signed({1'b0, level});
      lev   <= level;
      wsr   <= weight;
      acc   <= '0;
    end else if (ctrl.step) begin
      acc <= (acc <<< 1) + (wsr[WEIGHT_W-1] ? delta_ext : '0);
      wsr <= {wsr[WEIGHT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (ctrl.commit) begin
      avg <= avg_next;
    end
  end

endmodule

@@ rtl/core/three_channel_normalize_ema_unit.sv @@
// Each transfer on the input carries three raw samples; each is scaled to a
// level of 0 to 100 with LEVEL_FRACTION_BITS fraction bits and folded into
// that channel's moving average, and one transfer with the three averages
// follows on the output. Levels are LW bits wide, where LW =
// LEVEL_FRACTION_BITS + 7. The bit-serial dividers produce one level bit
// per cycle, then the prep state loads the blend, the bit-serial weight
// multiply runs, and the hold state writes the output register and returns
// to idle; no new transfer is taken while an item is in flight. A stalled
// output that still holds the previous result keeps the finished item
// waiting in the hold state. The user must write registers only while no
// item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// three_channel_normalize_ema_unit
// Three-channel load normalizer with exponential moving average.
// ----------------------------------------------------------------------------
`include "three_channel_normalize_ema_unit_assert.svh"

module three_channel_normalize_ema_unit #(
  parameter int LEVEL_FRACTION_BITS = tcne_pkg::LEVEL_FRAC_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcne_pkg::DATA_W-1:0]    cpu_sample,
  input  logic [tcne_pkg::DATA_W-1:0]    mem_sample_mb,
  input  logic [tcne_pkg::DATA_W-1:0]    io_sample,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcne_pkg::OUT_W-1:0]     cpu_level,
  output logic [tcne_pkg::OUT_W-1:0]     mem_level,
  output logic [tcne_pkg::OUT_W-1:0]     io_level,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcne_pkg::PADDR_W-1:0]   paddr,
  input  logic [tcne_pkg::DATA_W-1:0]    pwdata,
  output logic [tcne_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import tcne_pkg::*;

  localparam int LW = $clog2((LEVEL_SCALE << LEVEL_FRACTION_BITS) + 1);
  localparam int CW = $clog2((LW > WEIGHT_W) ? LW : WEIGHT_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_MUL,
    S_HOLD
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic              primed;
  logic              accept;
  logic              out_free;
  logic              cfg_write;

  logic [DATA_W-1:0]   cpu_scale;
  logic [DATA_W-1:0]   mem_scale;
  logic [DATA_W-1:0]   io_scale;
  logic [WEIGHT_W-1:0] weight;

  tcne_ctrl_t div_ctrl;
  tcne_ctrl_t blend_ctrl;

  logic [LW-1:0] cpu_lvl, mem_lvl, io_lvl;
  logic [LW-1:0] cpu_avg_next, mem_avg_next, io_avg_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign div_ctrl.load     = accept;
  assign div_ctrl.step     = (state == S_DIV);
  assign div_ctrl.commit   = 1'b0;
  assign blend_ctrl.load   = (state == S_PREP);
  assign blend_ctrl.step   = (state == S_MUL);
  assign blend_ctrl.commit = (state == S_HOLD) && out_free;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_scale <= CPU_SCALE_RESET;
      mem_scale <= MEM_SCALE_RESET;
      io_scale  <= IO_SCALE_RESET;
      weight    <= WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_CPU_SCALE: cpu_scale <= pwdata;
        REG_MEM_SCALE: mem_scale <= pwdata;
        REG_IO_SCALE:  io_scale  <= pwdata;
        REG_WEIGHT:    weight    <= pwdata[WEIGHT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CPU_SCALE: prdata = cpu_scale;
      REG_MEM_SCALE: prdata = mem_scale;
      REG_IO_SCALE:  prdata = io_scale;
      REG_WEIGHT:    prdata = DATA_W'(weight);
    endcase
  end

  // Sequencer, output register and the primed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In hold, a new result replaces the one leaving in the same cycle.
      if ((state != S_HOLD) && out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CW'(LW - 1)) begin
            cnt   <= '0;
            state <= S_PREP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PREP: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (cnt == CW'(WEIGHT_W - 1)) begin
            cnt   <= '0;
            state <= S_HOLD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            cpu_level <= OUT_W'(cpu_avg_next);
            mem_level <= OUT_W'(mem_avg_next);
            io_level  <= OUT_W'(io_avg_next);
            primed    <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tcne_div #(.FRAC_BITS(LEVEL_FRACTION_BITS)) u_cpu_div (
    .clk(clk), .ctrl(div_ctrl), .sample(cpu_sample), .scale(cpu_scale), .level(cpu_lvl)
  );
  tcne_div #(.FRAC_BITS(LEVEL_FRACTION_BITS)) u_mem_div (
    .clk(clk), .ctrl(div_ctrl), .sample(mem_sample_mb), .scale(mem_scale), .level(mem_lvl)
  );
  tcne_div #(.FRAC_BITS(LEVEL_FRACTION_BITS)) u_io_div (
    .clk(clk), .ctrl(div_ctrl), .sample(io_sample), .scale(io_scale), .level(io_lvl)
  );

  tcne_blend #(.FRAC_BITS(LEVEL_FRACTION_BITS)) u_cpu_blend (
    .clk(clk), .rst(rst), .ctrl(blend_ctrl), .primed(primed), .weight(weight),
    .level(cpu_lvl), .avg_next(cpu_avg_next)
  );
  tcne_blend #(.FRAC_BITS(LEVEL_FRACTION_BITS)) u_mem_blend (
    .clk(clk), .rst(rst), .ctrl(blend_ctrl), .primed(primed), .weight(weight),
    .level(mem_lvl), .avg_next(mem_avg_next)
  );
  tcne_blend #(.FRAC_BITS(LEVEL_FRACTION_BITS)) u_io_blend (
    .clk(clk), .rst(rst), .ctrl(blend_ctrl), .primed(primed), .weight(weight),
    .level(io_lvl), .avg_next(io_avg_next)
  );

  `TCNE_ASSERT_NEXT(a_accept_busy, clk, rst, accept, in_stall && (state == S_DIV),
    "accepted transfer did not start the divide")
  `TCNE_ASSERT_NEXT(a_hold_waits, clk, rst, (state == S_HOLD) && out_valid && out_stall,
    (state == S_HOLD), "result left hold while the output was still stalled")
  `TCNE_ASSERT_NOW(a_result_from_hold, clk, rst, $rose(out_valid), ($past(state) == S_HOLD),
    "output transfer raised outside the hold state")
  `TCNE_ASSERT_NEXT(a_primed_after_commit, clk, rst, blend_ctrl.commit, primed,
    "averages committed without setting the primed flag")

endmodule
